// ===== rtl/core/mdai_pkg.sv =====
// ----------------------------------------------------------------------------
// mdai_pkg
// Shared types, codes and arithmetic helpers of the matrix determinant,
// adjugate and inverse block.
// ----------------------------------------------------------------------------
package mdai_pkg;

  localparam int MaxOrder = 4;
  localparam int IdxW     = 2;
  localparam int OrdW     = 3;
  localparam int ElemW    = 32;
  localparam int ValW     = 64;
  localparam int ThrW     = 31;
  localparam int DivSteps = 96;
  localparam int CntW     = 7;

  localparam logic [1:0] MODE_DET = 2'd0;
  localparam logic [1:0] MODE_ADJ = 2'd1;
  localparam logic [1:0] MODE_INV = 2'd2;

  localparam logic [1:0] CFG_SIZE = 2'd0;
  localparam logic [1:0] CFG_MODE = 2'd1;
  localparam logic [1:0] CFG_THR  = 2'd2;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_SING = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam logic [ValW-1:0] Q_ONE   = 64'h0000_0001_0000_0000;
  localparam logic [ValW-1:0] I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [ValW-1:0] I64_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [3:0] {
    DP_NOP, DP_WRITE, DP_START, DP_PUSH, DP_RET0, DP_RET1, DP_RETACC, DP_POP,
    DP_MUL_LO, DP_MUL_HI, DP_TERM, DP_ACCUM, DP_SAVE_DET, DP_COF,
    DP_DIV_INIT, DP_DIV_STEP
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EVAL, ST_RET, ST_MUL_LO, ST_MUL_HI, ST_TERM, ST_ACCUM,
    ST_DONE, ST_CHK, ST_DIV_INIT, ST_DIV, ST_DIV_END, ST_EMIT, ST_NEXT
  } state_t;

  typedef struct packed {
    dp_op_t          op;
    logic            emit;
    logic [IdxW-1:0] i;
    logic [IdxW-1:0] j;
    logic            whole;
    logic            sat_init;
    logic            last;
    logic            singular;
    logic            div_end;
  } dp_cmd_t;

  typedef struct packed {
    logic left0;
    logic left1;
    logic col_found;
    logic lv_zero;
    logic div_last;
    logic singular;
    logic out_free;
  } dp_stat_t;

  function automatic logic [IdxW-1:0] first_one(input logic [MaxOrder-1:0] m);
    logic [IdxW-1:0] r;
    r = '0;
    for (int k = MaxOrder - 1; k >= 0; k--) begin
      if (m[k]) r = IdxW'(k);
    end
    return r;
  endfunction

  function automatic logic [ValW-1:0] mag64(input logic [ValW-1:0] v);
    return v[ValW-1] ? (~v + 64'd1) : v;
  endfunction

  // {sat, value}
  function automatic logic [ValW:0] from_mag(input logic neg, input logic [ValW-1:0] m);
    logic [ValW:0] r;
    if (!neg) begin
      r = m[ValW-1] ? {1'b1, I64_MAX} : {1'b0, m};
    end else begin
      r = (m[ValW-1] && (m[ValW-2:0] != '0)) ? {1'b1, I64_MIN} : {1'b0, ~m + 64'd1};
    end
    return r;
  endfunction

  function automatic logic [ValW:0] sat_add(input logic [ValW-1:0] a, input logic [ValW-1:0] b);
    logic [ValW-1:0] s;
    logic [ValW:0]   r;
    s = a + b;
    if ((a[ValW-1] == b[ValW-1]) && (s[ValW-1] != a[ValW-1])) begin
      r = a[ValW-1] ? {1'b1, I64_MIN} : {1'b1, I64_MAX};
    end else begin
      r = {1'b0, s};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/matrix_det_adj_inverse.sv =====
// ----------------------------------------------------------------------------
// matrix_det_adj_inverse
// Loads a Q16.16 matrix element by element and gives its determinant,
// adjugate or inverse by cofactor expansion, in Q32.32 with saturation.
// ----------------------------------------------------------------------------
// Each expansion term of a minor walk uses the one shared 32x32
// multiplier twice; inverse elements also pass through the
// one-bit-per-cycle divider.
// One item at a time; results stall on out_tready without losing data.
// Reset: sync active-low; size 4, mode determinant, threshold 1; store unset.
module matrix_det_adj_inverse (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // row_index, col_index, element
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // value, out_row, out_col, status
  output logic        out_tlast,  // last
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [30:0] cfg_wdata
);
  import mdai_pkg::*;

  logic [OrdW-1:0] size_r;
  logic [1:0]      mode_r;
  logic [ThrW-1:0] thr_r;
  logic [OrdW-1:0] order;
  logic [1:0]      mode_eff;
  dp_cmd_t         cmd;
  dp_stat_t        stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 3'd4;
      mode_r <= MODE_DET;
      thr_r  <= 31'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SIZE: size_r <= cfg_wdata[OrdW-1:0];
        CFG_MODE: mode_r <= cfg_wdata[1:0];
        CFG_THR:  thr_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamp the order to 1..MaxOrder; unused mode code behaves as determinant
  assign order    = (size_r == '0) ? 3'd1 :
                    (size_r > OrdW'(MaxOrder)) ? OrdW'(MaxOrder) : size_r;
  assign mode_eff = (mode_r == MODE_ADJ || mode_r == MODE_INV) ? mode_r : MODE_DET;

  mdai_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser),
    .order     (order),
    .mode      (mode_eff),
    .stat      (stat),
    .cmd       (cmd)
  );

  mdai_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .order      (order),
    .thr        (thr_r),
    .wr_row     (in_tdata[1:0]),
    .wr_col     (in_tdata[3:2]),
    .wr_elem    (in_tdata[35:4]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/core/mdai_dp.sv =====
// ----------------------------------------------------------------------------
// mdai_dp
// Datapath: element store, cofactor expansion frames, shared 32x32
// multiplier, bit-serial divider and output register.
// ----------------------------------------------------------------------------
module mdai_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mdai_pkg::dp_cmd_t                   cmd,
  output mdai_pkg::dp_stat_t                  stat,
  input  logic [mdai_pkg::OrdW-1:0]           order,
  input  logic [mdai_pkg::ThrW-1:0]           thr,
  input  logic [mdai_pkg::IdxW-1:0]           wr_row,
  input  logic [mdai_pkg::IdxW-1:0]           wr_col,
  input  logic [mdai_pkg::ElemW-1:0]          wr_elem,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [71:0]                         out_tdata,  // value, out_row, out_col, status
  output logic                                out_tlast   // last
);
  import mdai_pkg::*;

  logic [ElemW-1:0]    store_r [MaxOrder*MaxOrder];
  logic [IdxW-1:0]     lv_r;
  logic [MaxOrder-1:0] urows_r [MaxOrder];
  logic [MaxOrder-1:0] ucols_r [MaxOrder];
  logic [IdxW:0]       jpos_r  [MaxOrder];
  logic                kodd_r  [MaxOrder];
  logic [ValW-1:0]     acc_r   [MaxOrder];
  logic [ValW-1:0]     res_r, det_r, plo_r, phi_r, t_r, num_r, den_r, rem_r, q_r;
  logic                sat_r, dsat_r, neg_r, ovf_r, dneg_r;
  logic [CntW-1:0]     cnt_r;
  logic                out_valid_r, out_last_r;
  logic [ValW-1:0]     out_val_r;
  logic [IdxW-1:0]     out_row_r, out_col_r;
  logic [1:0]          out_st_r;

  logic [4:0]          ord_sh;
  logic [MaxOrder-1:0] nmask, cur_u, cur_c, rowfree, colfree, geq, cand;
  logic [IdxW-1:0]     fr, fcol, leafcol, rdcol, lv_up;
  logic [ElemW-1:0]    elem, amag;
  logic [ValW-1:0]     bmag, prod, rsum, dmag;
  logic [ValW:0]       fm, sa, r2;
  logic                rdb;

  assign ord_sh  = 5'd1 << order;
  assign nmask   = ord_sh[MaxOrder-1:0] - 4'd1;
  assign lv_up   = lv_r + 2'd1;
  assign cur_u   = urows_r[lv_r];
  assign cur_c   = ucols_r[lv_r];
  assign rowfree = ~cur_u & nmask;
  assign colfree = ~cur_c & nmask;
  always_comb begin
    for (int k = 0; k < MaxOrder; k++) geq[k] = ((IdxW+1)'(k) >= jpos_r[lv_r]);
  end
  assign cand    = colfree & geq;
  assign fr      = first_one(rowfree);
  assign fcol    = first_one(cand);
  assign leafcol = first_one(colfree);
  assign rdcol   = (cmd.op == DP_RET1) ? leafcol : jpos_r[lv_r][IdxW-1:0];
  assign elem    = store_r[{fr, rdcol}];

  // magnitudes for the shared multiplier
  assign amag = elem[ElemW-1] ? (~elem + 32'd1) : elem;
  assign bmag = mag64(res_r);
  assign prod = ValW'(amag) * ValW'((cmd.op == DP_MUL_LO) ? bmag[31:0] : bmag[63:32]);

  assign rsum = {phi_r[47:0], 16'd0} + {16'd0, plo_r[63:16]};
  assign dmag = mag64(det_r);
  assign rdb  = (cnt_r >= CntW'(32)) ? num_r[ValW-1] : 1'b0;
  assign r2   = {rem_r, rdb};

  always_comb begin
    fm = '0;
    sa = '0;
    case (cmd.op)
      DP_TERM:     fm = from_mag(neg_r, rsum);
      DP_COF:      fm = from_mag(!res_r[ValW-1], bmag);
      DP_DIV_STEP: fm = from_mag(dneg_r, q_r);
      default:     fm = from_mag(dneg_r, q_r);
    endcase
    sa = sat_add(acc_r[lv_r], t_r);
  end

  assign stat.left0     = (rowfree == '0);
  assign stat.left1     = $onehot(rowfree);
  assign stat.col_found = (cand != '0);
  assign stat.lv_zero   = (lv_r == '0);
  assign stat.div_last  = (cnt_r == '0);
  assign stat.singular  = (det_r == '0) || (dmag < {17'd0, thr, 16'd0});
  assign stat.out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_WRITE: store_r[{wr_row, wr_col}] <= wr_elem;
      DP_START: begin
        lv_r       <= '0;
        urows_r[0] <= cmd.whole ? '0 : (MaxOrder'(1) << cmd.j);
        ucols_r[0] <= cmd.whole ? '0 : (MaxOrder'(1) << cmd.i);
        jpos_r[0]  <= '0;
        kodd_r[0]  <= 1'b0;
        acc_r[0]   <= '0;
        sat_r      <= cmd.sat_init & dsat_r;
      end
      DP_PUSH: begin
        jpos_r[lv_r]   <= {1'b0, fcol};
        urows_r[lv_up] <= cur_u | (MaxOrder'(1) << fr);
        ucols_r[lv_up] <= cur_c | (MaxOrder'(1) << fcol);
        jpos_r[lv_up]  <= '0;
        kodd_r[lv_up]  <= 1'b0;
        acc_r[lv_up]   <= '0;
        lv_r           <= lv_up;
      end
      DP_RET0:   res_r <= Q_ONE;
      DP_RET1:   res_r <= {{16{elem[ElemW-1]}}, elem, 16'd0};
      DP_RETACC: res_r <= acc_r[lv_r];
      DP_POP:    lv_r  <= lv_r - 2'd1;
      DP_MUL_LO: begin
        plo_r <= prod;
        neg_r <= elem[ElemW-1] ^ res_r[ValW-1] ^ kodd_r[lv_r];
      end
      DP_MUL_HI: phi_r <= prod;
      DP_TERM: begin
        if (phi_r[63:47] != '0) begin
          t_r   <= neg_r ? I64_MIN : I64_MAX;
          sat_r <= 1'b1;
        end else begin
          t_r   <= fm[ValW-1:0];
          sat_r <= sat_r | fm[ValW];
        end
      end
      DP_ACCUM: begin
        acc_r[lv_r]  <= sa[ValW-1:0];
        sat_r        <= sat_r | sa[ValW];
        jpos_r[lv_r] <= jpos_r[lv_r] + 3'd1;
        kodd_r[lv_r] <= ~kodd_r[lv_r];
      end
      DP_SAVE_DET: begin
        det_r  <= res_r;
        dsat_r <= sat_r;
      end
      DP_COF: begin
        if (cmd.i[0] ^ cmd.j[0]) begin
          res_r <= fm[ValW-1:0];
          sat_r <= sat_r | fm[ValW];
        end
      end
      DP_DIV_INIT: begin
        num_r  <= bmag;
        den_r  <= dmag;
        rem_r  <= '0;
        q_r    <= '0;
        ovf_r  <= 1'b0;
        cnt_r  <= CntW'(DivSteps - 1);
        dneg_r <= res_r[ValW-1] ^ det_r[ValW-1];
      end
      DP_DIV_STEP: begin
        num_r <= {num_r[ValW-2:0], 1'b0};
        if (q_r[ValW-1]) ovf_r <= 1'b1;
        if (r2 >= {1'b0, den_r}) begin
          rem_r <= 64'(r2 - {1'b0, den_r});
          q_r   <= {q_r[ValW-2:0], 1'b1};
        end else begin
          rem_r <= r2[ValW-1:0];
          q_r   <= {q_r[ValW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 7'd1;
      end
      default: ;
    endcase
    if (cmd.div_end) begin
      if (ovf_r) begin
        res_r <= dneg_r ? I64_MIN : I64_MAX;
        sat_r <= 1'b1;
      end else begin
        res_r <= fm[ValW-1:0];
        sat_r <= sat_r | fm[ValW];
      end
    end
    if (cmd.emit) begin
      out_val_r  <= cmd.singular ? '0 : res_r;
      out_row_r  <= cmd.i;
      out_col_r  <= cmd.j;
      out_st_r   <= cmd.singular ? STATUS_SING : (sat_r ? STATUS_SAT : STATUS_OK);
      out_last_r <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'd0, out_st_r, out_col_r, out_row_r, out_val_r};
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  a_push_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_PUSH) |-> (lv_r != 2'd3))
    else $error("expansion pushed beyond the deepest frame");
  a_pop_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_POP) |-> (lv_r != 2'd0))
    else $error("expansion popped the outermost frame");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_tready))
    else $error("result overwrote an untaken result");
`endif

endmodule

// ===== rtl/core/mdai_ctrl.sv =====
// ----------------------------------------------------------------------------
// mdai_ctrl
// Controller: sequences loads, cofactor expansion, the adjugate walk, the
// divider and result hand-off.
// ----------------------------------------------------------------------------
module mdai_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic                      in_op,
  input  logic [mdai_pkg::OrdW-1:0] order,
  input  logic [1:0]                mode,
  input  mdai_pkg::dp_stat_t        stat,
  output mdai_pkg::dp_cmd_t         cmd
);
  import mdai_pkg::*;

  state_t          state_r, state_nxt;
  logic [IdxW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic            det_r, det_nxt, sing_r, sing_nxt;
  logic [OrdW-1:0] lst_w;
  logic [IdxW-1:0] lst;
  logic            at_end;

  assign lst_w  = order - 3'd1;
  assign lst    = lst_w[IdxW-1:0];
  assign at_end = (i_r == lst) && (j_r == lst);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      det_r   <= 1'b0;
      sing_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      det_r   <= det_nxt;
      sing_r  <= sing_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    det_nxt      = det_r;
    sing_nxt     = sing_r;
    in_tready    = 1'b0;
    cmd          = '0;
    cmd.op       = DP_NOP;
    cmd.i        = i_r;
    cmd.j        = j_r;
    cmd.whole    = det_r;
    cmd.sat_init = (mode == MODE_INV);
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_op == OP_WRITE) begin
            cmd.op = DP_WRITE;
          end else begin
            det_nxt      = (mode != MODE_ADJ);
            i_nxt        = '0;
            j_nxt        = '0;
            cmd.op       = DP_START;
            cmd.i        = '0;
            cmd.j        = '0;
            cmd.whole    = (mode != MODE_ADJ);
            cmd.sat_init = 1'b0;
            state_nxt    = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        if (stat.left0) begin
          cmd.op = DP_RET0;
          state_nxt = ST_RET;
        end else if (stat.left1) begin
          cmd.op = DP_RET1;
          state_nxt = ST_RET;
        end else if (stat.col_found) begin
          cmd.op = DP_PUSH;
        end else begin
          cmd.op = DP_RETACC;
          state_nxt = ST_RET;
        end
      end
      ST_RET: begin
        if (stat.lv_zero) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.op    = DP_POP;
          state_nxt = ST_MUL_LO;
        end
      end
      ST_MUL_LO: begin
        cmd.op    = DP_MUL_LO;
        state_nxt = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.op    = DP_MUL_HI;
        state_nxt = ST_TERM;
      end
      ST_TERM: begin
        cmd.op    = DP_TERM;
        state_nxt = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd.op    = DP_ACCUM;
        state_nxt = ST_EVAL;
      end
      ST_DONE: begin
        if (det_r) begin
          if (mode == MODE_INV) begin
            cmd.op    = DP_SAVE_DET;
            state_nxt = ST_CHK;
          end else begin
            state_nxt = ST_EMIT;
          end
        end else begin
          cmd.op    = DP_COF;
          state_nxt = (mode == MODE_INV) ? ST_DIV_INIT : ST_EMIT;
        end
      end
      ST_CHK: begin
        if (stat.singular) begin
          sing_nxt  = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          det_nxt      = 1'b0;
          cmd.op       = DP_START;
          cmd.whole    = 1'b0;
          cmd.sat_init = 1'b1;
          state_nxt    = ST_EVAL;
        end
      end
      ST_DIV_INIT: begin
        cmd.op    = DP_DIV_INIT;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.op = DP_DIV_STEP;
        if (stat.div_last) state_nxt = ST_DIV_END;
      end
      ST_DIV_END: begin
        cmd.div_end = 1'b1;
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.singular = sing_r;
          cmd.last     = det_r || at_end;
          if (det_r || at_end) begin
            sing_nxt  = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            // advance to the next result element, row major
            if (j_r == lst) begin
              j_nxt = '0;
              i_nxt = i_r + 2'd1;
            end else begin
              j_nxt = j_r + 2'd1;
            end
            state_nxt = ST_NEXT;
          end
        end
      end
      ST_NEXT: begin
        cmd.op    = DP_START;
        cmd.whole = 1'b0;
        state_nxt = ST_EVAL;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
